// ----- design/sqltok_pkg.sv -----
// Package for the SQL subset tokenizer: token and scan mode codes, record and
// queue entry types, character class helpers. No dependencies.
package sqltok_pkg;

  localparam int TEXT_MAX_DEF    = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_IDENT,
    MODE_INT,
    MODE_STR,
    MODE_MINUS,
    MODE_BANG,
    MODE_LT,
    MODE_GT
  } mode_t;

  typedef enum logic [4:0] {
    TOK_EOF    = 5'd0,
    TOK_IDENT  = 5'd1,
    TOK_NULL   = 5'd2,
    TOK_INT    = 5'd3,
    TOK_STR    = 5'd4,
    TOK_LPAREN = 5'd5,
    TOK_RPAREN = 5'd6,
    TOK_COMMA  = 5'd7,
    TOK_SEMI   = 5'd8,
    TOK_STAR   = 5'd9,
    TOK_EQ     = 5'd10,
    TOK_NEQ    = 5'd11,
    TOK_LT     = 5'd12,
    TOK_LTE    = 5'd13,
    TOK_GT     = 5'd14,
    TOK_GTE    = 5'd15,
    TOK_ERROR  = 5'd16
  } tok_type_t;

  localparam logic       KIND_TEXT = 1'b0;
  localparam logic       KIND_END  = 1'b1;
  localparam logic [2:0] NULL_FAIL = 3'd7;
  localparam logic [2:0] NULL_DONE = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_STAR   = 8'h2A;

  typedef struct packed {
    logic        kind;
    tok_type_t   ttype;
    logic [7:0]  tbyte;
    logic [4:0]  tlen;
    logic [63:0] ival;
  } rec_t;

  // Everything one input transaction produces: one or two records.
  typedef struct packed {
    rec_t rec0;
    rec_t rec1;
    logic two;
  } pair_t;

  localparam rec_t REC_NONE = '0;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == 8'h5F);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'h20) : c;
  endfunction

  // Letters of the keyword NULL, indexed by match position.
  function automatic logic [7:0] null_letter(input logic [1:0] idx);
    logic [7:0] l;
    unique case (idx)
      2'd0:    l = 8'h4E;
      2'd1:    l = 8'h55;
      default: l = 8'h4C;
    endcase
    return l;
  endfunction

  function automatic logic [2:0] null_step(input logic [2:0] nm, input logic [7:0] c);
    logic [2:0] r;
    if (nm < NULL_DONE && to_upper(c) == null_letter(nm[1:0])) begin
      r = nm + 3'd1;
    end else begin
      r = NULL_FAIL;
    end
    return r;
  endfunction

  function automatic rec_t mk_text(input tok_type_t t, input logic [7:0] c);
    rec_t r;
    r       = REC_NONE;
    r.kind  = KIND_TEXT;
    r.ttype = t;
    r.tbyte = c;
    return r;
  endfunction

  function automatic rec_t mk_end(input tok_type_t t, input logic [7:0] b,
                                  input logic [4:0] len, input logic [63:0] v);
    rec_t r;
    r.kind  = KIND_END;
    r.ttype = t;
    r.tbyte = b;
    r.tlen  = len;
    r.ival  = v;
    return r;
  endfunction

endpackage

// ----- design/sql_subset_tokenizer.sv -----
// Top level of the SQL subset tokenizer: scanner, pair queue and output stage.
// Depends on sqltok_pkg, sqltok_scan, sqltok_queue and sqltok_emit.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------------
//   in_     | input     | push / full        | in_char_byte, in_end_of_input
//   out_    | output    | pop / empty        | kind, type, byte, length, int value, last
//
// Flow: a byte is taken in every cycle in which the pair queue has room; each byte causes
// zero, one or two result records, and the output register hands out one record a cycle
// while pop is held, so a run of two-record bytes is paced by the output port.
// The edge that accepts a byte transaction writes its pair into the pair queue; the output
// register then loads it from the queue once the register is empty or its record is popped.
// Reset is synchronous and active low; it returns the scanner to idle and empties the queue
// and the output register.
// A stalled output side fills the queue of QUEUE_DEPTH pairs and then raises full.
module sql_subset_tokenizer #(
  parameter int TEXT_MAX    = sqltok_pkg::TEXT_MAX_DEF,
  parameter int QUEUE_DEPTH = sqltok_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         in_char_byte,
  input  logic               in_end_of_input,
  output logic               empty,
  input  logic               pop,
  output logic               out_record_kind,
  output logic [4:0]         out_token_type,
  output logic [7:0]         out_text_byte,
  output logic [4:0]         out_text_length,
  output logic signed [63:0] out_int_value,
  output logic               out_last
);

  // The scanner advances on every accepted byte transaction; a pair is pushed only when
  // the byte produced a record (whitespace between tokens and comments produce none).
  logic              take;
  logic              has_recs;
  sqltok_pkg::pair_t scan_pair;

  logic              q_full;
  logic              q_empty;
  logic              q_deq;
  sqltok_pkg::pair_t q_head;

  logic              emit_valid;
  sqltok_pkg::rec_t  emit_rec;
  logic              emit_last;

  assign take = push && !q_full;
  assign full = q_full;

  sqltok_scan #(
    .TEXT_MAX (TEXT_MAX)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (take),
    .char_byte    (in_char_byte),
    .end_of_input (in_end_of_input),
    .has_recs     (has_recs),
    .pair         (scan_pair)
  );

  sqltok_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (take && has_recs),
    .wr_pair (scan_pair),
    .full    (q_full),
    .empty   (q_empty),
    .deq     (q_deq),
    .head    (q_head)
  );

  // The output stage refills its register whenever it is empty or its record is being
  // taken, so it sustains one record per cycle while pop is held and the queue has pairs.
  sqltok_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_deq     (q_deq),
    .pop       (pop),
    .out_valid (emit_valid),
    .out_rec   (emit_rec),
    .out_last  (emit_last)
  );

  assign empty           = !emit_valid;
  assign out_record_kind = emit_rec.kind;
  assign out_token_type  = emit_rec.ttype;
  assign out_text_byte   = emit_rec.tbyte;
  assign out_text_length = emit_rec.tlen;
  assign out_int_value   = $signed(emit_rec.ival);
  assign out_last        = emit_last;

  // The second record of a pair is already in the queue, so it must follow at once.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop && !out_last) |=> !empty)
    else $error("second record of a pair did not follow its first");

  // Text records only ever belong to identifiers, integers or strings.
  a_text_class: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_record_kind == sqltok_pkg::KIND_TEXT) |->
    (out_token_type == sqltok_pkg::TOK_IDENT || out_token_type == sqltok_pkg::TOK_INT ||
     out_token_type == sqltok_pkg::TOK_STR))
    else $error("text record with a non-text token class");

  // An EOF record is always the final end record of its transaction.
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_token_type == sqltok_pkg::TOK_EOF &&
     out_record_kind == sqltok_pkg::KIND_END) |-> out_last)
    else $error("EOF record not marked last");

  // While the queue is full the scanner holds its state.
  a_queue_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |=> ($stable(u_scan.mode_r) || !rst_n))
    else $error("scanner advanced while the queue was full");

endmodule

// ----- design/sqltok_scan.sv -----
// Front end of the tokenizer: scan state machine that classifies each byte
// and builds the zero, one or two records it causes. Uses sqltok_pkg.
module sqltok_scan #(
  parameter int TEXT_MAX = sqltok_pkg::TEXT_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        char_byte,
  input  logic              end_of_input,
  output logic              has_recs,
  output sqltok_pkg::pair_t pair
);

  localparam int KLW = $clog2(TEXT_MAX);
  localparam logic [KLW-1:0] KEEP_LIM = KLW'(TEXT_MAX - 1);

  sqltok_pkg::mode_t mode_r, mode_nxt;
  logic [KLW-1:0]    kept_r, kept_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic              neg_r, neg_nxt;
  logic [2:0]        nm_r, nm_nxt;

  logic [KLW+4:0]    kept_ext;
  logic [4:0]        kept_len;
  logic [63:0]       acc_step;
  logic [63:0]       acc_neg;
  logic              is_end;
  logic              room;

  logic              fin_vld;
  sqltok_pkg::rec_t  fin_rec;

  sqltok_pkg::mode_t st_mode;
  logic [KLW-1:0]    st_kept;
  logic [63:0]       st_acc;
  logic              st_neg;
  logic [2:0]        st_nm;
  logic              st_vld;
  sqltok_pkg::rec_t  st_rec;
  sqltok_pkg::tok_type_t st_punct;

  logic              a_vld, b_vld;
  sqltok_pkg::rec_t  a_rec, b_rec;

  assign kept_ext = {5'd0, kept_r};
  assign kept_len = kept_ext[4:0];
  assign acc_step = (acc_r << 3) + (acc_r << 1) + {60'd0, char_byte[3:0]};
  assign acc_neg  = 64'd0 - acc_r;
  assign is_end   = end_of_input || (char_byte == sqltok_pkg::CH_NUL);
  assign room     = kept_r < KEEP_LIM;

  // Record that closes whatever token or pending operator is open.
  always_comb begin
    fin_vld = 1'b1;
    fin_rec = sqltok_pkg::REC_NONE;
    unique case (mode_r)
      sqltok_pkg::MODE_IDENT:
        fin_rec = sqltok_pkg::mk_end((nm_r == sqltok_pkg::NULL_DONE) ? sqltok_pkg::TOK_NULL
                                     : sqltok_pkg::TOK_IDENT, 8'd0, kept_len, 64'd0);
      sqltok_pkg::MODE_INT:
        fin_rec = sqltok_pkg::mk_end(sqltok_pkg::TOK_INT, 8'd0, kept_len,
                                     neg_r ? acc_neg : acc_r);
      sqltok_pkg::MODE_STR:
        fin_rec = sqltok_pkg::mk_end(sqltok_pkg::TOK_STR, 8'd0, kept_len, 64'd0);
      sqltok_pkg::MODE_MINUS:
        fin_rec = sqltok_pkg::mk_end(sqltok_pkg::TOK_ERROR, sqltok_pkg::CH_MINUS, 5'd0, 64'd0);
      sqltok_pkg::MODE_BANG:
        fin_rec = sqltok_pkg::mk_end(sqltok_pkg::TOK_ERROR, sqltok_pkg::CH_BANG, 5'd0, 64'd0);
      sqltok_pkg::MODE_LT:
        fin_rec = sqltok_pkg::mk_end(sqltok_pkg::TOK_LT, 8'd0, 5'd0, 64'd0);
      sqltok_pkg::MODE_GT:
        fin_rec = sqltok_pkg::mk_end(sqltok_pkg::TOK_GT, 8'd0, 5'd0, 64'd0);
      default:
        fin_vld = 1'b0;
    endcase
  end

  // Single-byte punctuation lookup for a fresh token.
  always_comb begin
    unique case (char_byte)
      sqltok_pkg::CH_LPAREN: st_punct = sqltok_pkg::TOK_LPAREN;
      sqltok_pkg::CH_RPAREN: st_punct = sqltok_pkg::TOK_RPAREN;
      sqltok_pkg::CH_COMMA:  st_punct = sqltok_pkg::TOK_COMMA;
      sqltok_pkg::CH_SEMI:   st_punct = sqltok_pkg::TOK_SEMI;
      sqltok_pkg::CH_STAR:   st_punct = sqltok_pkg::TOK_STAR;
      sqltok_pkg::CH_EQ:     st_punct = sqltok_pkg::TOK_EQ;
      default:               st_punct = sqltok_pkg::TOK_ERROR;
    endcase
  end

  // Outcome of scanning the byte as the first byte of a new token.
  always_comb begin
    st_mode = sqltok_pkg::MODE_IDLE;
    st_kept = kept_r;
    st_acc  = acc_r;
    st_neg  = neg_r;
    st_nm   = nm_r;
    st_vld  = 1'b0;
    st_rec  = sqltok_pkg::REC_NONE;
    priority if (sqltok_pkg::is_space(char_byte)) begin
      st_mode = sqltok_pkg::MODE_IDLE;
    end else if (char_byte == sqltok_pkg::CH_QUOTE) begin
      st_mode = sqltok_pkg::MODE_STR;
      st_kept = '0;
      st_acc  = 64'd0;
      st_neg  = 1'b0;
      st_nm   = 3'd0;
    end else if (sqltok_pkg::is_digit(char_byte)) begin
      st_mode = sqltok_pkg::MODE_INT;
      st_kept = KLW'(1);
      st_acc  = {60'd0, char_byte[3:0]};
      st_neg  = 1'b0;
      st_nm   = 3'd0;
      st_vld  = 1'b1;
      st_rec  = sqltok_pkg::mk_text(sqltok_pkg::TOK_INT, char_byte);
    end else if (sqltok_pkg::is_alpha(char_byte)) begin
      st_mode = sqltok_pkg::MODE_IDENT;
      st_kept = KLW'(1);
      st_acc  = 64'd0;
      st_neg  = 1'b0;
      st_nm   = sqltok_pkg::null_step(3'd0, char_byte);
      st_vld  = 1'b1;
      st_rec  = sqltok_pkg::mk_text(sqltok_pkg::TOK_IDENT, char_byte);
    end else if (char_byte == sqltok_pkg::CH_MINUS) begin
      st_mode = sqltok_pkg::MODE_MINUS;
    end else if (char_byte == sqltok_pkg::CH_BANG) begin
      st_mode = sqltok_pkg::MODE_BANG;
    end else if (char_byte == sqltok_pkg::CH_LT) begin
      st_mode = sqltok_pkg::MODE_LT;
    end else if (char_byte == sqltok_pkg::CH_GT) begin
      st_mode = sqltok_pkg::MODE_GT;
    end else begin
      st_vld = 1'b1;
      st_rec = sqltok_pkg::mk_end(st_punct,
                                  (st_punct == sqltok_pkg::TOK_ERROR) ? char_byte : 8'd0,
                                  5'd0, 64'd0);
    end
  end

  // Next state and the ordered records for this byte.
  always_comb begin
    mode_nxt = mode_r;
    kept_nxt = kept_r;
    acc_nxt  = acc_r;
    neg_nxt  = neg_r;
    nm_nxt   = nm_r;
    a_vld    = 1'b0;
    a_rec    = sqltok_pkg::REC_NONE;
    b_vld    = 1'b0;
    b_rec    = sqltok_pkg::REC_NONE;
    if (is_end) begin
      a_vld    = fin_vld;
      a_rec    = fin_rec;
      b_vld    = 1'b1;
      b_rec    = sqltok_pkg::mk_end(sqltok_pkg::TOK_EOF, 8'd0, 5'd0, 64'd0);
      mode_nxt = sqltok_pkg::MODE_IDLE;
      kept_nxt = '0;
      acc_nxt  = 64'd0;
      neg_nxt  = 1'b0;
      nm_nxt   = 3'd0;
    end else begin
      unique case (mode_r)
        sqltok_pkg::MODE_COMMENT: begin
          if (char_byte == sqltok_pkg::CH_LF) begin
            mode_nxt = sqltok_pkg::MODE_IDLE;
          end
        end
        sqltok_pkg::MODE_STR: begin
          if (char_byte == sqltok_pkg::CH_QUOTE) begin
            a_vld    = 1'b1;
            a_rec    = fin_rec;
            mode_nxt = sqltok_pkg::MODE_IDLE;
          end else if (room) begin
            a_vld    = 1'b1;
            a_rec    = sqltok_pkg::mk_text(sqltok_pkg::TOK_STR, char_byte);
            kept_nxt = kept_r + KLW'(1);
          end
        end
        sqltok_pkg::MODE_IDENT: begin
          if (sqltok_pkg::is_alpha(char_byte) || sqltok_pkg::is_digit(char_byte)) begin
            nm_nxt = sqltok_pkg::null_step(nm_r, char_byte);
            if (room) begin
              a_vld    = 1'b1;
              a_rec    = sqltok_pkg::mk_text(sqltok_pkg::TOK_IDENT, char_byte);
              kept_nxt = kept_r + KLW'(1);
            end
          end else begin
            a_vld = 1'b1;
            a_rec = fin_rec;
            b_vld = st_vld;
            b_rec = st_rec;
            mode_nxt = st_mode;
            kept_nxt = st_kept;
            acc_nxt  = st_acc;
            neg_nxt  = st_neg;
            nm_nxt   = st_nm;
          end
        end
        sqltok_pkg::MODE_INT: begin
          if (sqltok_pkg::is_digit(char_byte)) begin
            if (room) begin
              a_vld    = 1'b1;
              a_rec    = sqltok_pkg::mk_text(sqltok_pkg::TOK_INT, char_byte);
              kept_nxt = kept_r + KLW'(1);
              acc_nxt  = acc_step;
            end
          end else begin
            a_vld = 1'b1;
            a_rec = fin_rec;
            b_vld = st_vld;
            b_rec = st_rec;
            mode_nxt = st_mode;
            kept_nxt = st_kept;
            acc_nxt  = st_acc;
            neg_nxt  = st_neg;
            nm_nxt   = st_nm;
          end
        end
        sqltok_pkg::MODE_MINUS: begin
          if (char_byte == sqltok_pkg::CH_MINUS) begin
            mode_nxt = sqltok_pkg::MODE_COMMENT;
          end else if (sqltok_pkg::is_digit(char_byte)) begin
            // Negative integer: the minus sign is the first kept text byte.
            a_vld    = 1'b1;
            a_rec    = sqltok_pkg::mk_text(sqltok_pkg::TOK_INT, sqltok_pkg::CH_MINUS);
            b_vld    = 1'b1;
            b_rec    = sqltok_pkg::mk_text(sqltok_pkg::TOK_INT, char_byte);
            mode_nxt = sqltok_pkg::MODE_INT;
            kept_nxt = KLW'(2);
            acc_nxt  = {60'd0, char_byte[3:0]};
            neg_nxt  = 1'b1;
            nm_nxt   = 3'd0;
          end else begin
            a_vld = 1'b1;
            a_rec = fin_rec;
            b_vld = st_vld;
            b_rec = st_rec;
            mode_nxt = st_mode;
            kept_nxt = st_kept;
            acc_nxt  = st_acc;
            neg_nxt  = st_neg;
            nm_nxt   = st_nm;
          end
        end
        sqltok_pkg::MODE_BANG, sqltok_pkg::MODE_LT, sqltok_pkg::MODE_GT: begin
          if (char_byte == sqltok_pkg::CH_EQ) begin
            a_vld = 1'b1;
            a_rec = sqltok_pkg::mk_end((mode_r == sqltok_pkg::MODE_BANG) ? sqltok_pkg::TOK_NEQ :
                                       ((mode_r == sqltok_pkg::MODE_LT) ? sqltok_pkg::TOK_LTE :
                                        sqltok_pkg::TOK_GTE), 8'd0, 5'd0, 64'd0);
            mode_nxt = sqltok_pkg::MODE_IDLE;
          end else begin
            a_vld = 1'b1;
            a_rec = fin_rec;
            b_vld = st_vld;
            b_rec = st_rec;
            mode_nxt = st_mode;
            kept_nxt = st_kept;
            acc_nxt  = st_acc;
            neg_nxt  = st_neg;
            nm_nxt   = st_nm;
          end
        end
        default: begin
          b_vld    = st_vld;
          b_rec    = st_rec;
          mode_nxt = st_mode;
          kept_nxt = st_kept;
          acc_nxt  = st_acc;
          neg_nxt  = st_neg;
          nm_nxt   = st_nm;
        end
      endcase
    end
  end

  // Close up the gap when only the second slot holds a record.
  always_comb begin
    has_recs = a_vld || b_vld;
    pair.two = a_vld && b_vld;
    if (a_vld) begin
      pair.rec0 = a_rec;
      pair.rec1 = b_rec;
    end else begin
      pair.rec0 = b_rec;
      pair.rec1 = sqltok_pkg::REC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sqltok_pkg::MODE_IDLE;
      kept_r <= '0;
      acc_r  <= 64'd0;
      neg_r  <= 1'b0;
      nm_r   <= 3'd0;
    end else if (take) begin
      mode_r <= mode_nxt;
      kept_r <= kept_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      nm_r   <= nm_nxt;
    end
  end

endmodule

// ----- design/sqltok_queue.sv -----
// Short queue of record pairs between the scanner and the output stage.
// Uses sqltok_pkg.
module sqltok_queue #(
  parameter int DEPTH = sqltok_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sqltok_pkg::pair_t wr_pair,
  output logic              full,
  output logic              empty,
  input  logic              deq,
  output sqltok_pkg::pair_t head
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sqltok_pkg::pair_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = deq && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_pair;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- design/sqltok_emit.sv -----
// Back end of the tokenizer: walks each queued pair one record at a time
// into the output register and marks the final record. Uses sqltok_pkg.
module sqltok_emit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  sqltok_pkg::pair_t q_head,
  output logic              q_deq,
  input  logic              pop,
  output logic              out_valid,
  output sqltok_pkg::rec_t  out_rec,
  output logic              out_last
);

  logic             vld_r, vld_nxt;
  logic             sel_r, sel_nxt;
  sqltok_pkg::rec_t rec_r, rec_nxt;
  logic             last_r, last_nxt;
  logic             load;
  logic             head_last;

  assign load      = !vld_r || pop;
  assign head_last = sel_r || !q_head.two;

  always_comb begin
    vld_nxt  = vld_r;
    sel_nxt  = sel_r;
    rec_nxt  = rec_r;
    last_nxt = last_r;
    q_deq    = 1'b0;
    if (load) begin
      vld_nxt = !q_empty;
      if (!q_empty) begin
        rec_nxt  = sel_r ? q_head.rec1 : q_head.rec0;
        last_nxt = head_last;
        q_deq    = head_last;
        sel_nxt  = !head_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      sel_r <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r  <= rec_nxt;
    last_r <= last_nxt;
  end

  assign out_valid = vld_r;
  assign out_rec   = rec_r;
  assign out_last  = last_r;

endmodule
